// ----- sv/swc_pkg.sv -----
// Shared types and constants for the sliding window covariance block.
`timescale 1ns / 1ps
package swc_pkg;
	localparam int WINDOW_DEF = 64;
	localparam int DIV_W = 48;
	localparam int DEN_W = 13;
	localparam int MEAN_W = 25;
	localparam int PROD_W = 50;
	localparam int TERM_W = 33;
	localparam logic [31:0] INIT_VAR_RST = 32'h0001_0000;

	typedef struct packed {
		logic ld;
		logic idx_clr;
		logic idx_inc;
		logic rd_en;
		logic sum_clr;
		logic sum_acc;
		logic dev_ld;
		logic mac_en;
		logic [2:0] mac_sel;
		logic div_start;
		logic div_term;
		logic [2:0] div_k;
		logic out_ld;
	} swc_cmd_t;

	typedef struct packed {
		logic fill_ge2;
		logic idx_last;
		logic div_done;
		logic out_busy;
	} swc_sts_t;
endpackage

// ----- sv/swc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module swc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [swc_pkg::DIV_W-1:0] dividend,
	input  logic [swc_pkg::DEN_W-1:0] divisor,
	output logic [swc_pkg::DIV_W-1:0] quo,
	output logic                      done
);
	import swc_pkg::*;

	localparam int CW = $clog2(DIV_W);

	logic [DIV_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rs;
	logic             ge;
	logic [DEN_W:0]   rd;

	assign rs = {rem_q, quo_q[DIV_W-1]};
	assign ge = rs >= {1'b0, den_q};
	assign rd = ge ? rs - {1'b0, den_q} : rs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= rd[DEN_W-1:0];
		end
	end

	assign quo  = quo_q;
	assign done = done_q;
endmodule

// ----- sv/swc_dp.sv -----
// Datapath: sample ring, sums, means, deviation products and term division.
`timescale 1ns / 1ps
module swc_dp #(
	parameter int WINDOW = swc_pkg::WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  swc_pkg::swc_cmd_t                 cmd,
	output swc_pkg::swc_sts_t                 sts,
	input  logic                              cfg_we,
	input  logic [31:0]                       cfg_wdata,
	input  logic [47:0]                       in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [6*swc_pkg::TERM_W-1:0]      out_terms,
	output logic                              out_updated
);
	import swc_pkg::*;

	localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FW = $clog2(WINDOW + 1);
	localparam int SUM_W = 16 + $clog2(WINDOW) + 1;
	localparam int ACC_W = PROD_W + $clog2(WINDOW) + 1;
	localparam logic [DIV_W-1:0] QMAX_POS = DIV_W'(33'h0_FFFF_FFFF);
	localparam logic [DIV_W-1:0] QMAX_NEG = DIV_W'(33'h1_0000_0000);

	logic [47:0] mem [WINDOW];
	logic [47:0] rdata_q;
	logic        rd_v_s1;
	logic [AW-1:0] wpos_q;
	logic [AW-1:0] idx_q;
	logic [FW-1:0] fill_q;
	logic [31:0]   init_q;

	logic signed [SUM_W-1:0]  sum_q  [3];
	logic signed [MEAN_W-1:0] mean_q [3];
	logic signed [MEAN_W-1:0] dev_q  [3];
	logic signed [ACC_W-1:0]  acc_q  [6];
	logic signed [TERM_W-1:0] term_q [6];

	logic signed [MEAN_W-1:0] opa, opb;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] prod_s1;
	logic [2:0]               sel_s1;
	logic                     pv_s1;

	logic signed [SUM_W-1:0]  sum_sel;
	logic signed [ACC_W-1:0]  dv;
	logic [ACC_W-1:0]         dmag;
	logic [DIV_W-1:0]         dividend;
	logic [DEN_W-1:0]         divisor;
	logic [DIV_W-1:0]         quo;
	logic                     div_done;
	logic                     neg_q;
	logic [TERM_W-1:0]        qt;

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			mem[wpos_q] <= in_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q    <= '0;
			fill_q    <= '0;
			idx_q     <= '0;
			rd_v_s1   <= 1'b0;
			pv_s1     <= 1'b0;
			out_valid <= 1'b0;
			init_q    <= INIT_VAR_RST;
		end else begin
			rd_v_s1 <= cmd.rd_en;
			pv_s1   <= cmd.mac_en;
			if (cfg_we) begin
				init_q <= cfg_wdata;
			end
			if (cmd.ld) begin
				wpos_q <= (wpos_q == AW'(WINDOW - 1)) ? '0 : wpos_q + AW'(1);
				if (fill_q < FW'(WINDOW)) begin
					fill_q <= fill_q + FW'(1);
				end
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end
			if (cmd.out_ld) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		case (cmd.mac_sel)
			3'd0: begin opa = dev_q[0]; opb = dev_q[0]; end
			3'd1: begin opa = dev_q[1]; opb = dev_q[1]; end
			3'd2: begin opa = dev_q[2]; opb = dev_q[2]; end
			3'd3: begin opa = dev_q[0]; opb = dev_q[1]; end
			3'd4: begin opa = dev_q[0]; opb = dev_q[2]; end
			3'd5: begin opa = dev_q[1]; opb = dev_q[2]; end
			default: begin opa = '0; opb = '0; end
		endcase
	end
	assign prod_c = opa * opb;

	always_comb begin
		case (cmd.div_k)
			3'd0: sum_sel = sum_q[0];
			3'd1: sum_sel = sum_q[1];
			3'd2: sum_sel = sum_q[2];
			default: sum_sel = '0;
		endcase
	end
	assign dv = cmd.div_term ? acc_q[cmd.div_k] : ACC_W'(sum_sel);
	assign dmag = dv[ACC_W-1] ? ACC_W'(-dv) : ACC_W'(dv);
	assign dividend = cmd.div_term ? DIV_W'(dmag >> 16) : DIV_W'(dmag << 8);
	assign divisor = cmd.div_term ? DEN_W'(fill_q) - DEN_W'(1) : DEN_W'(fill_q);

	swc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.quo      (quo),
		.done     (div_done)
	);

	always_comb begin
		if (!neg_q) begin
			qt = (quo > QMAX_POS) ? TERM_W'(QMAX_POS) : TERM_W'(quo);
		end else begin
			qt = (quo > QMAX_NEG) ? TERM_W'(QMAX_NEG) : TERM_W'(0) - TERM_W'(quo);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			for (int i = 0; i < 3; i++) sum_q[i] <= '0;
			for (int i = 0; i < 6; i++) acc_q[i] <= '0;
		end else begin
			if (rd_v_s1 && cmd.sum_acc) begin
				sum_q[0] <= sum_q[0] + SUM_W'($signed(rdata_q[15:0]));
				sum_q[1] <= sum_q[1] + SUM_W'($signed(rdata_q[31:16]));
				sum_q[2] <= sum_q[2] + SUM_W'($signed(rdata_q[47:32]));
			end
			if (pv_s1) begin
				acc_q[sel_s1] <= acc_q[sel_s1] + ACC_W'(prod_s1);
			end
		end
		if (cmd.dev_ld) begin
			dev_q[0] <= MEAN_W'($signed({rdata_q[15:0], 8'h00})) - mean_q[0];
			dev_q[1] <= MEAN_W'($signed({rdata_q[31:16], 8'h00})) - mean_q[1];
			dev_q[2] <= MEAN_W'($signed({rdata_q[47:32], 8'h00})) - mean_q[2];
		end
		prod_s1 <= prod_c;
		sel_s1  <= cmd.mac_sel;
		if (cmd.div_start) begin
			neg_q <= dv[ACC_W-1];
		end
		if (div_done) begin
			if (cmd.div_term) begin
				term_q[cmd.div_k] <= qt;
			end else begin
				mean_q[cmd.div_k[1:0]] <= neg_q ? MEAN_W'(0) - MEAN_W'(quo) : MEAN_W'(quo);
			end
		end
		if (cmd.out_ld) begin
			if (sts.fill_ge2) begin
				out_terms <= {term_q[5], term_q[4], term_q[3],
					term_q[2], term_q[1], term_q[0]};
			end else begin
				out_terms <= {{3{TERM_W'(0)}}, {3{TERM_W'(init_q)}}};
			end
			out_updated <= sts.fill_ge2;
		end
	end

	assign sts.fill_ge2 = fill_q >= FW'(2);
	assign sts.idx_last = FW'(idx_q) == fill_q - FW'(1);
	assign sts.div_done = div_done;
	assign sts.out_busy = out_valid && !out_ready;

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> !(out_valid && !out_ready))
		else $error("result overwritten while pending");
	a_prod_src: assert property (@(posedge clk) disable iff (!arst_n)
		pv_s1 |-> $past(cmd.mac_en))
		else $error("product without multiply");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld |=> fill_q != '0)
		else $error("fill count stuck at zero");
endmodule

// ----- sv/swc_ctrl.sv -----
// Controller sequencing the two window passes and the divisions.
`timescale 1ns / 1ps
module swc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  swc_pkg::swc_sts_t sts,
	output swc_pkg::swc_cmd_t cmd
);
	import swc_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CHK  = 4'd1;
	localparam logic [3:0] ST_S1   = 4'd2;
	localparam logic [3:0] ST_S1W  = 4'd3;
	localparam logic [3:0] ST_MS   = 4'd4;
	localparam logic [3:0] ST_MW   = 4'd5;
	localparam logic [3:0] ST_P2R  = 4'd6;
	localparam logic [3:0] ST_P2W  = 4'd7;
	localparam logic [3:0] ST_P2M  = 4'd8;
	localparam logic [3:0] ST_P2D  = 4'd9;
	localparam logic [3:0] ST_TS   = 4'd10;
	localparam logic [3:0] ST_TW   = 4'd11;
	localparam logic [3:0] ST_DONE = 4'd12;

	logic [3:0] state_q, state_d;
	logic [2:0] k_q, k_d;
	logic [2:0] m_q, m_d;

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		state_d = state_q;
		k_d = k_q;
		m_d = m_q;
		cmd = '0;
		cmd.mac_sel = m_q;
		cmd.div_k = k_q;
		cmd.div_term = (state_q == ST_TS) || (state_q == ST_TW);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.ld = 1'b1;
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (sts.fill_ge2) begin
					cmd.sum_clr = 1'b1;
					cmd.idx_clr = 1'b1;
					state_d = ST_S1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_S1: begin
				cmd.rd_en = 1'b1;
				cmd.sum_acc = 1'b1;
				if (sts.idx_last) begin
					state_d = ST_S1W;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_S1W: begin
				cmd.sum_acc = 1'b1;
				k_d = 3'd0;
				state_d = ST_MS;
			end
			ST_MS: begin
				cmd.div_start = 1'b1;
				state_d = ST_MW;
			end
			ST_MW: begin
				if (sts.div_done) begin
					if (k_q == 3'd2) begin
						cmd.idx_clr = 1'b1;
						state_d = ST_P2R;
					end else begin
						k_d = k_q + 3'd1;
						state_d = ST_MS;
					end
				end
			end
			ST_P2R: begin
				cmd.rd_en = 1'b1;
				state_d = ST_P2W;
			end
			ST_P2W: begin
				cmd.dev_ld = 1'b1;
				m_d = 3'd0;
				state_d = ST_P2M;
			end
			ST_P2M: begin
				cmd.mac_en = 1'b1;
				if (m_q == 3'd5) begin
					if (sts.idx_last) begin
						state_d = ST_P2D;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d = ST_P2R;
					end
				end else begin
					m_d = m_q + 3'd1;
				end
			end
			ST_P2D: begin
				k_d = 3'd0;
				state_d = ST_TS;
			end
			ST_TS: begin
				cmd.div_start = 1'b1;
				state_d = ST_TW;
			end
			ST_TW: begin
				if (sts.div_done) begin
					if (k_q == 3'd5) begin
						state_d = ST_DONE;
					end else begin
						k_d = k_q + 3'd1;
						state_d = ST_TS;
					end
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_ld = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			m_q <= '0;
		end else begin
			state_q <= state_d;
			k_q <= k_d;
			m_q <= m_d;
		end
	end
endmodule

// ----- sv/sliding_window_covariance_3d_top.sv -----
// Top level of the sliding window 3x3 sample covariance block.
//
// Input words on s_axis carry one (x, y, z) Q8.8 error sample. Each word
// enters a ring of the last WINDOW samples; every word yields one result
// word on m_axis with the six Q16.16 terms and the updated flag.
// With n samples held (n >= 2) the result takes one read pass for the
// sums, three serial divisions for the means (each: start, 48 quotient
// bits, finish), a second pass with a shared multiplier doing six
// products per sample, then six serial divisions for the terms. With
// fewer than two samples the controller goes from the check straight to
// the result, which reports init_variance on the diagonals. One item is
// worked at a time; the next word can be accepted in the cycle after the
// result is loaded.
// The result register parts the channels: the next word is taken while a
// result waits; a stalled receiver holds the following item in its last
// state until the waiting word leaves.
// Reset clears the window fill count, write position and init_variance
// (to 1.0); no clearing pass is needed. The user must write init_variance
// through cfg_we/cfg_wdata while the block is idle; nothing enforces this.
`timescale 1ns / 1ps
module sliding_window_covariance_3d_top #(
	parameter int WINDOW = swc_pkg::WINDOW_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,  // err_x, err_y, err_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [199:0] m_axis_tdata,  // var_x, var_y, var_z, cov_xy, cov_xz, cov_yz, pad
	output logic [0:0]   m_axis_tuser   // updated
);
	import swc_pkg::*;

	swc_cmd_t cmd;
	swc_sts_t sts;
	logic [6*TERM_W-1:0] terms;
	logic upd;
	logic acc_in;

	assign acc_in = s_axis_tvalid;

	swc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (acc_in),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	swc_dp #(.WINDOW(WINDOW)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_data     (s_axis_tdata),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_terms   (terms),
		.out_updated (upd)
	);

	assign m_axis_tdata = {2'b00, terms};
	assign m_axis_tuser = upd;
endmodule

// ----- tb/sliding_window_covariance_3d_top_tb.sv -----
// Self-checking testbench for the sliding window 3x3 sample covariance block.
`timescale 1ns / 1ps
module sliding_window_covariance_3d_top_tb;
	import swc_pkg::*;

	localparam int WIN = WINDOW_DEF;
	localparam longint TERM_HI = 64'sd4294967295;
	localparam longint TERM_LO = -64'sd4294967296;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [TERM_W-1:0] term [6];
		logic              upd;
	} cov_word_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [31:0]  cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [47:0]  s_axis_tdata;  // err_x, err_y, err_z
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [199:0] m_axis_tdata;  // var_x, var_y, var_z, cov_xy, cov_xz, cov_yz, pad
	logic [0:0]   m_axis_tuser;  // updated

	sliding_window_covariance_3d_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// predictor state
	shortint   win_x [WIN];
	shortint   win_y [WIN];
	shortint   win_z [WIN];
	int        wr_pos;
	int        n_held;
	logic [31:0] init_var;
	logic [TERM_W-1:0] held_terms [6];

	cov_word_t cov_expected [$];
	int        n_sent;
	int        n_recv;
	int        n_updated;
	int        n_mismatch;
	int        idle_cnt;
	bit        no_gaps;
	string     term_name [6] = '{"var_x", "var_y", "var_z", "cov_xy", "cov_xz", "cov_yz"};

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [TERM_W-1:0] sat_term(longint acc, longint den);
		longint q;
		q = acc / den;
		if (q > TERM_HI)
			q = TERM_HI;
		if (q < TERM_LO)
			q = TERM_LO;
		return q[TERM_W-1:0];
	endfunction

	function automatic cov_word_t predict_cov(shortint ex, shortint ey, shortint ez);
		cov_word_t r;
		longint sx, sy, sz, mx, my, mz, dx, dy, dz, den;
		longint acc [6];
		sx = 0; sy = 0; sz = 0;
		for (int k = 0; k < 6; k++)
			acc[k] = 0;
		win_x[wr_pos] = ex;
		win_y[wr_pos] = ey;
		win_z[wr_pos] = ez;
		wr_pos = (wr_pos + 1) % WIN;
		if (n_held < WIN)
			n_held++;
		if (n_held >= 2) begin
			for (int i = 0; i < n_held; i++) begin
				sx += win_x[i];
				sy += win_y[i];
				sz += win_z[i];
			end
			mx = (sx * 256) / n_held;
			my = (sy * 256) / n_held;
			mz = (sz * 256) / n_held;
			for (int i = 0; i < n_held; i++) begin
				dx = longint'(win_x[i]) * 256 - mx;
				dy = longint'(win_y[i]) * 256 - my;
				dz = longint'(win_z[i]) * 256 - mz;
				acc[0] += dx * dx;
				acc[1] += dy * dy;
				acc[2] += dz * dz;
				acc[3] += dx * dy;
				acc[4] += dx * dz;
				acc[5] += dy * dz;
			end
			den = longint'(n_held - 1) * 65536;
			for (int k = 0; k < 6; k++)
				held_terms[k] = sat_term(acc[k], den);
			r.upd = 1'b1;
		end else begin
			for (int k = 0; k < 3; k++)
				held_terms[k] = {1'b0, init_var};
			for (int k = 3; k < 6; k++)
				held_terms[k] = '0;
			r.upd = 1'b0;
		end
		r.term = held_terms;
		return r;
	endfunction

	task automatic send_sample(shortint ex, shortint ey, shortint ez);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {ez, ey, ex};
		do
			@(posedge clk);
		while (!s_axis_tready);
		cov_expected.push_back(predict_cov(ex, ey, ez));
		n_sent++;
	endtask

	task automatic drain;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (cov_expected.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_init_var(logic [31:0] v);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		init_var = v;
	endtask

	function automatic shortint rand_sample(int mode);
		case (mode)
			0: return shortint'($urandom);
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return shortint'($urandom_range(0, 1023)) - 16'sd512;
		endcase
	endfunction

	task automatic test_startup_and_extremes;
		write_init_var(32'hffff_ffff);
		no_gaps = 1'b1;
		send_sample(16'sh7fff, 16'sh8000, 16'sh0000);  // single sample: init diagonals
		send_sample(16'sh8000, 16'sh7fff, -16'sd1);
		send_sample(16'sh0000, 16'sh0000, 16'sh0000);
		send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_sample(16'sh8000, 16'sh8000, 16'sh8000);
		no_gaps = 1'b0;
		for (int i = 0; i < 10; i++)
			send_sample(i[0] ? 16'sh7fff : 16'sh8000, i[0] ? 16'sh8000 : 16'sh7fff,
				i[1] ? 16'sh7fff : 16'sh8000);
		send_sample(16'sh0001, -16'sd1, 16'sh0100);
		send_sample(16'sh5555, 16'shaaaa, 16'sh00ff);
		send_sample(16'shaaaa, 16'sh5555, 16'shff00);
	endtask

	task automatic test_register_settings;
		write_init_var(32'h0000_0000);
		for (int i = 0; i < 4; i++)
			send_sample(rand_sample(0), rand_sample(0), rand_sample(0));
		write_init_var($urandom);
		for (int i = 0; i < 4; i++)
			send_sample(rand_sample(2), rand_sample(2), rand_sample(2));
	endtask

	task automatic test_random_windows;
		int mode;
		for (int i = 0; i < 850; i++) begin
			if (i % 200 == 199)
				write_init_var(i[8] ? 32'h0001_0000 : $urandom);
			no_gaps = (i % 150) < 20;
			mode = $urandom_range(0, 9);
			mode = (mode < 6) ? 0 : (mode < 8) ? 2 : 1;
			send_sample(rand_sample(mode), rand_sample(mode), rand_sample(mode));
		end
		drain();
	endtask

	// result side
	initial begin
		int gap;
		cov_word_t e;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = no_gaps ? 0 : $urandom_range(0, 7);
			repeat (gap) begin
				@(negedge clk);
				m_axis_tready = 1'b0;
			end
			@(negedge clk);
			m_axis_tready = 1'b1;
			do
				@(posedge clk);
			while (!m_axis_tvalid);
			n_recv++;
			if (m_axis_tuser[0])
				n_updated++;
			if (cov_expected.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("ERROR: result word %0d with nothing expected", n_recv);
			end else begin
				e = cov_expected.pop_front();
				for (int k = 0; k < 6; k++) begin
					if (m_axis_tdata[k*TERM_W +: TERM_W] !== e.term[k]) begin
						n_mismatch++;
						if (n_mismatch <= 10)
							$display("ERROR: word %0d %s expected %h got %h", n_recv,
								term_name[k], e.term[k], m_axis_tdata[k*TERM_W +: TERM_W]);
					end
				end
				if (m_axis_tuser[0] !== e.upd) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("ERROR: word %0d updated expected %b got %b", n_recv,
							e.upd, m_axis_tuser[0]);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= STALL_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		wr_pos = 0;
		n_held = 0;
		init_var = INIT_VAR_RST;
		n_sent = 0;
		no_gaps = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_startup_and_extremes();
		test_register_settings();
		test_random_windows();
		$display("Fed %0d samples through the %0d-deep window; %0d result words, %0d recomputed.",
			n_sent, WIN, n_recv, n_updated);
		$display("init_variance swept over zero, all ones, reset and random values.");
		if (n_mismatch == 0)
			$display("Simulation PASSED");
		else begin
			$display("%0d mismatches", n_mismatch);
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
